/* rtl/qrs_pkg.sv */
// Shared types and codes for the quadratic root solver.
// No dependencies; the solver top level, qrs_check and the testbench import this package.
package qrs_pkg;

	typedef enum logic [1:0] {
		DEG_CONST  = 2'd0,
		DEG_LINEAR = 2'd1,
		DEG_QUAD   = 2'd2,
		DEG_HIGH   = 2'd3
	} deg_t;

	typedef enum logic [2:0] {
		CASE_ALL     = 3'd0,
		CASE_NONE    = 3'd1,
		CASE_LINEAR  = 3'd2,
		CASE_REAL    = 3'd3,
		CASE_DOUBLE  = 3'd4,
		CASE_COMPLEX = 3'd5,
		CASE_HIGH    = 3'd6
	} case_code_t;

endpackage

/* rtl/qrs_in_if.sv */
// Coefficient channel of the quadratic root solver: valid/ready plus one word.
// No dependencies.
interface qrs_in_if #(parameter int COEF_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   poly_degree;
	logic signed [COEF_WIDTH-1:0] coef_zero;
	logic signed [COEF_WIDTH-1:0] coef_one;
	logic signed [COEF_WIDTH-1:0] coef_two;

	modport source (output valid, poly_degree, coef_zero, coef_one, coef_two, input ready);
	modport sink (input valid, poly_degree, coef_zero, coef_one, coef_two, output ready);
endinterface

/* rtl/qrs_out_if.sv */
// Result channel of the quadratic root solver: valid/ready plus one word.
// No dependencies.
interface qrs_out_if #(parameter int COEF_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   case_code;
	logic signed [COEF_WIDTH-1:0] first_value;
	logic signed [COEF_WIDTH-1:0] second_value;
	logic                         overflow_flag;

	modport source (output valid, case_code, first_value, second_value, overflow_flag,
		input ready);
	modport sink (input valid, case_code, first_value, second_value, overflow_flag,
		output ready);
endinterface

/* rtl/quadratic_root_solver_top.sv */
// Quadratic root solver top level: split, products, discriminant, square root,
// numerators, two dividers, saturation. Uses qrs_pkg, qrs_isqrt, qrs_div, qrs_*_if.
//
//  channel | dir | word
//  --------+-----+------------------------------------------------------------
//  req     | in  | poly_degree, coef_zero, coef_one, coef_two
//  rsp     | out | case_code, first_value, second_value, overflow_flag
//
// One word enters per cycle while rsp is not stalled; the longest parts of the pipe are the
// square root (COEF_WIDTH+1 stages) and the dividers (COEF_WIDTH+2).
// The whole pipe advances whenever the output register is empty or taken; a stall
// on rsp holds every stage and drops req.ready in the same cycle.
// arst_n clears all valid bits; payload registers are not reset.
module quadratic_root_solver_top import qrs_pkg::*; #(
	parameter int COEF_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input logic       clk,
	input logic       arst_n,
	qrs_in_if.sink    req,
	qrs_out_if.source rsp
);

	localparam int W      = COEF_WIDTH;
	localparam int DW     = 2*W+2;
	localparam int NW     = W+2;
	localparam int SQ_LAT = W+1;
	localparam int DV_LAT = W+2;

	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		deg_t         deg;
		logic         an;
		logic         bn;
		logic         cn;
		logic [W-1:0] am;
		logic [W-1:0] bm;
		logic [W-1:0] cm;
		logic         dz;
		logic         dn;
	} sb_t;

	typedef struct packed {
		case_code_t code;
		logic       a_neg;
		logic       a_zero;
		logic       b_neg;
		logic       b_zero;
		logic       d_neg;
		logic       d_zero;
	} dv_t;

	logic adv;

	// stage 1: split into sign and magnitude
	logic [W-1:0] raw_a, raw_b, raw_c;
	logic [W-1:0] am_c, bm_c, cm_c;

	logic         v_s1;
	deg_t         deg_s1;
	logic         an_s1, bn_s1, cn_s1;
	logic [W-1:0] am_s1, bm_s1, cm_s1;

	// stage 2: products
	logic           v_s2;
	sb_t            sb_s2;
	logic [2*W-1:0] bb_s2, ac_s2;

	// stage 3: discriminant
	logic signed [DW:0] bb_x, fac_x, disc_c, dneg_c;
	sb_t                sb3_c;
	logic               v_s3;
	sb_t                sb_s3;
	logic [DW-1:0]      rad_s3;

	// square root line
	logic [SQ_LAT-1:0] v_sq;
	sb_t               sb_sq [SQ_LAT];
	logic [W:0]        root_sq;

	// stage 4: numerators and divisor
	sb_t                sb4;
	logic signed [W+2:0] bmx, negb, sx, na_c, nb_c, nam_c, nbm_c;
	logic [W:0]          dm_c;
	logic                dn_c;
	case_code_t          code_c;

	logic        v_s4;
	dv_t         dv_s4;
	logic [NW-1:0] na_s4, nb_s4;
	logic [W:0]  dm_s4;

	// divider line
	logic [DV_LAT-1:0] v_dv;
	dv_t               dv_sb [DV_LAT];
	logic [W:0]        qa, qb;
	logic              biga, bigb;

	// output
	dv_t          dvo;
	logic [W:0]   ra, rb;
	logic [W-1:0] f_c, s_c;
	logic         o_c;

	logic         out_v_q;
	case_code_t   out_code_q;
	logic [W-1:0] out_first_q, out_second_q;
	logic         out_ovf_q;

	function automatic logic [W:0] sat_fn(input logic big, input logic [W:0] q,
		input logic nneg, input logic nzero, input logic dneg, input logic dzero);
		logic         qneg;
		logic         ovf;
		logic [W-1:0] val;
		qneg = nneg ^ dneg;
		ovf  = 1'b0;
		if (dzero) begin
			ovf = 1'b1;
			val = nzero ? '0 : (nneg ? VMIN : VMAX);
		end else if (!qneg) begin
			if (big || q > {1'b0, VMAX}) begin
				ovf = 1'b1;
				val = VMAX;
			end else begin
				val = q[W-1:0];
			end
		end else begin
			if (big || q > {1'b0, VMIN}) begin
				ovf = 1'b1;
				val = VMIN;
			end else begin
				val = ~q[W-1:0] + 1'b1;
			end
		end
		return {ovf, val};
	endfunction

	assign adv       = !out_v_q || rsp.ready;
	assign req.ready = adv;

	assign raw_a = req.coef_two;
	assign raw_b = req.coef_one;
	assign raw_c = req.coef_zero;
	assign am_c  = raw_a[W-1] ? ~raw_a + 1'b1 : raw_a;
	assign bm_c  = raw_b[W-1] ? ~raw_b + 1'b1 : raw_b;
	assign cm_c  = raw_c[W-1] ? ~raw_c + 1'b1 : raw_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_sq    <= '0;
			v_s4    <= 1'b0;
			v_dv    <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= req.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_sq    <= {v_sq[SQ_LAT-2:0], v_s3};
			v_s4    <= v_sq[SQ_LAT-1];
			v_dv    <= {v_dv[DV_LAT-2:0], v_s4};
			out_v_q <= v_dv[DV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s1 <= deg_t'(req.poly_degree);
			an_s1  <= raw_a[W-1];
			bn_s1  <= raw_b[W-1];
			cn_s1  <= raw_c[W-1];
			am_s1  <= am_c;
			bm_s1  <= bm_c;
			cm_s1  <= cm_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s2.deg <= deg_s1;
			sb_s2.an  <= an_s1;
			sb_s2.bn  <= bn_s1;
			sb_s2.cn  <= cn_s1;
			sb_s2.am  <= am_s1;
			sb_s2.bm  <= bm_s1;
			sb_s2.cm  <= cm_s1;
			sb_s2.dz  <= 1'b0;
			sb_s2.dn  <= 1'b0;
			bb_s2     <= (2*W)'(bm_s1) * (2*W)'(bm_s1);
			ac_s2     <= (2*W)'(am_s1) * (2*W)'(cm_s1);
		end
	end

	assign bb_x   = signed'({3'b000, bb_s2});
	assign fac_x  = signed'({1'b0, ac_s2, 2'b00});
	assign disc_c = (sb_s2.an != sb_s2.cn) ? bb_x + fac_x : bb_x - fac_x;
	assign dneg_c = -disc_c;

	always_comb begin
		sb3_c    = sb_s2;
		sb3_c.dz = disc_c == '0;
		sb3_c.dn = disc_c[DW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s3  <= sb3_c;
			rad_s3 <= disc_c[DW] ? dneg_c[DW-1:0] : disc_c[DW-1:0];
		end
	end

	qrs_isqrt #(.W(W)) u_isqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_s3),
		.root (root_sq)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_sq[0] <= sb_s3;
			for (int k = 1; k < SQ_LAT; k++) begin
				sb_sq[k] <= sb_sq[k-1];
			end
		end
	end

	assign sb4   = sb_sq[SQ_LAT-1];
	assign bmx   = signed'({3'b000, sb4.bm});
	assign negb  = sb4.bn ? bmx : -bmx;
	assign sx    = signed'({2'b00, root_sq});

	always_comb begin
		na_c   = '0;
		nb_c   = '0;
		dm_c   = '0;
		dn_c   = 1'b0;
		code_c = CASE_HIGH;
		case (sb4.deg)
			DEG_CONST: begin
				code_c = (sb4.cm == '0) ? CASE_ALL : CASE_NONE;
			end
			DEG_LINEAR: begin
				code_c = CASE_LINEAR;
				na_c   = sb4.cn ? signed'({3'b000, sb4.cm}) : -signed'({3'b000, sb4.cm});
				dm_c   = {1'b0, sb4.bm};
				dn_c   = sb4.bn;
			end
			DEG_QUAD: begin
				dm_c = {sb4.am, 1'b0};
				dn_c = sb4.an;
				if (sb4.dz) begin
					code_c = CASE_DOUBLE;
					na_c   = negb;
				end else if (!sb4.dn) begin
					code_c = CASE_REAL;
					na_c   = negb + sx;
					nb_c   = negb - sx;
				end else begin
					code_c = CASE_COMPLEX;
					na_c   = negb;
					nb_c   = sx;
				end
			end
			default: begin
				code_c = CASE_HIGH;
			end
		endcase
	end

	assign nam_c = na_c[W+2] ? -na_c : na_c;
	assign nbm_c = nb_c[W+2] ? -nb_c : nb_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s4.code   <= code_c;
			dv_s4.a_neg  <= na_c[W+2];
			dv_s4.a_zero <= na_c == '0;
			dv_s4.b_neg  <= nb_c[W+2];
			dv_s4.b_zero <= nb_c == '0;
			dv_s4.d_neg  <= dn_c;
			dv_s4.d_zero <= dm_c == '0;
			na_s4        <= nam_c[NW-1:0];
			nb_s4        <= nbm_c[NW-1:0];
			dm_s4        <= dm_c;
		end
	end

	qrs_div #(.W(W), .F(FRAC_BITS)) u_div_a (
		.clk  (clk),
		.en   (adv),
		.nmag (na_s4),
		.dmag (dm_s4),
		.quo  (qa),
		.big  (biga)
	);

	qrs_div #(.W(W), .F(FRAC_BITS)) u_div_b (
		.clk  (clk),
		.en   (adv),
		.nmag (nb_s4),
		.dmag (dm_s4),
		.quo  (qb),
		.big  (bigb)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_sb[0] <= dv_s4;
			for (int k = 1; k < DV_LAT; k++) begin
				dv_sb[k] <= dv_sb[k-1];
			end
		end
	end

	assign dvo = dv_sb[DV_LAT-1];
	assign ra  = sat_fn(biga, qa, dvo.a_neg, dvo.a_zero, dvo.d_neg, dvo.d_zero);
	assign rb  = sat_fn(bigb, qb, dvo.b_neg, dvo.b_zero, dvo.d_neg, dvo.d_zero);

	always_comb begin
		f_c = '0;
		s_c = '0;
		o_c = 1'b0;
		case (dvo.code)
			CASE_REAL: begin
				o_c = ra[W] | rb[W];
				if (signed'(rb[W-1:0]) > signed'(ra[W-1:0])) begin
					f_c = rb[W-1:0];
					s_c = ra[W-1:0];
				end else begin
					f_c = ra[W-1:0];
					s_c = rb[W-1:0];
				end
			end
			CASE_COMPLEX: begin
				o_c = ra[W] | rb[W];
				f_c = ra[W-1:0];
				s_c = rb[W-1:0];
			end
			CASE_LINEAR, CASE_DOUBLE: begin
				o_c = ra[W];
				f_c = ra[W-1:0];
			end
			default: begin
				o_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_code_q   <= dvo.code;
			out_first_q  <= f_c;
			out_second_q <= s_c;
			out_ovf_q    <= o_c;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.case_code     = out_code_q;
	assign rsp.first_value   = out_first_q;
	assign rsp.second_value  = out_second_q;
	assign rsp.overflow_flag = out_ovf_q;

endmodule

/* rtl/qrs_isqrt.sv */
// Pipelined integer square root, one result bit per stage, W+1 stages.
// No package dependencies; instantiated by the solver top level.
module qrs_isqrt #(
	parameter int W = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [2*W+1:0]   rad,
	output logic [W:0]       root
);

	localparam int RW = 2*W+2;
	localparam int N  = W+1;

	logic [W+1:0]  rem_s  [N];
	logic [W:0]    root_s [N];
	logic [RW-1:0] rad_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [W+1:0]  rem_in;
		logic [W:0]    root_in;
		logic [RW-1:0] rad_in;
		logic [W+3:0]  cur;
		logic [W+3:0]  trial;
		logic [W+3:0]  diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
		end

		assign cur   = {rem_in, rad_in[RW-1:RW-2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign diff  = cur - trial;
		assign ge    = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[W+1:0] : cur[W+1:0];
				root_s[k] <= {root_in[W-1:0], ge};
				rad_s[k]  <= {rad_in[RW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[N-1];

endmodule

/* rtl/qrs_div.sv */
// Pipelined restoring divider: (nmag << F) / dmag, one quotient bit per stage.
// A front stage flags quotients of W+2 bits or more. No package use.
module qrs_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W+1:0] nmag,
	input  logic [W:0]   dmag,
	output logic [W:0]   quo,
	output logic         big
);

	localparam int NW = W+2+F;
	localparam int N  = W+1;

	logic [NW-1:0] nm;
	logic [NW-1:0] hi_x;
	logic [NW-1:0] d_x;
	logic          big_c;

	logic          big_p;
	logic [W:0]    rem_p;
	logic [W:0]    low_p;
	logic [W:0]    d_p;

	logic [W:0]    rem_s [N];
	logic [W:0]    low_s [N];
	logic [W:0]    q_s   [N];
	logic [W:0]    d_s   [N];
	logic          big_s [N];

	assign nm    = {nmag, {F{1'b0}}};
	assign hi_x  = nm >> (W+1);
	assign d_x   = NW'(dmag);
	assign big_c = hi_x >= d_x;

	always_ff @(posedge clk) begin
		if (en) begin
			big_p <= big_c;
			rem_p <= big_c ? '0 : hi_x[W:0];
			low_p <= nm[W:0];
			d_p   <= dmag;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [W:0]   rem_in;
		logic [W:0]   low_in;
		logic [W:0]   q_in;
		logic [W:0]   d_in;
		logic         big_in;
		logic [W+1:0] cur;
		logic [W+1:0] diff;
		logic         ge;

		if (k == 0) begin : g_first
			assign rem_in = rem_p;
			assign low_in = low_p;
			assign q_in   = '0;
			assign d_in   = d_p;
			assign big_in = big_p;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign low_in = low_s[k-1];
			assign q_in   = q_s[k-1];
			assign d_in   = d_s[k-1];
			assign big_in = big_s[k-1];
		end

		assign cur  = {rem_in, low_in[W]};
		assign ge   = cur >= {1'b0, d_in};
		assign diff = cur - {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[W:0] : cur[W:0];
				low_s[k] <= {low_in[W-1:0], 1'b0};
				q_s[k]   <= {q_in[W-1:0], ge};
				d_s[k]   <= d_in;
				big_s[k] <= big_in;
			end
		end
	end

	assign quo = q_s[N-1];
	assign big = big_s[N-1];

endmodule

/* rtl/qrs_check.sv */
// Port-level checks on the quadratic root solver result channel.
// Uses qrs_pkg; bound to quadratic_root_solver_top at the end of this file.
module qrs_check import qrs_pkg::*; #(
	parameter int W = 32
) (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [2:0]          code,
	input logic signed [W-1:0] first,
	input logic signed [W-1:0] second,
	input logic                ovf
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(code) && $stable(first)
			&& $stable(second) && $stable(ovf))
		else $error("result word changed while stalled");

	a_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (code == CASE_ALL || code == CASE_NONE || code == CASE_HIGH)
			|-> first == '0 && second == '0 && !ovf)
		else $error("values present in a case without roots");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (code == CASE_LINEAR || code == CASE_DOUBLE) |-> second == '0)
		else $error("second value set for a single root");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && code == CASE_REAL |-> first >= second)
		else $error("real roots out of order");

endmodule

bind quadratic_root_solver_top qrs_check #(.W(COEF_WIDTH)) u_qrs_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.code      (rsp.case_code),
	.first     (rsp.first_value),
	.second    (rsp.second_value),
	.ovf       (rsp.overflow_flag)
);

/* sim/tb_quadratic_root_solver_top.sv */
// Testbench for quadratic_root_solver_top: directed and random coefficient words with
// random gaps and output stalls, results checked against a built-in root predictor.
// Depends on qrs_pkg, qrs_in_if, qrs_out_if and the solver RTL.
module tb_quadratic_root_solver_top;
	import qrs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int N_RANDOM = 1930;
	localparam int LIMIT = 400000;
	localparam logic signed [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		case_code_t          code;
		logic signed [CW-1:0] first;
		logic signed [CW-1:0] second;
		logic                ovf;
	} roots_t;

	class root_scoreboard;
		roots_t roots_q[$];
		int     fails;

		function automatic logic signed [CW-1:0] divide_sat(logic signed [127:0] num,
				bit dneg, logic [63:0] dmag, inout bit ovf);
			logic [127:0] nm;
			logic [127:0] q;
			bit           nneg;
			nneg = num < 0;
			nm = (nneg ? -num : num) << FB;
			if (dmag == 0) begin
				ovf = 1;
				if (nm == 0) return '0;
				return nneg ? VMIN : VMAX;
			end
			q = nm / {64'd0, dmag};
			if (nneg == dneg) begin
				if (q > {1'b0, VMAX}) begin
					ovf = 1;
					return VMAX;
				end
				return q[CW-1:0];
			end
			if (q > {1'b0, VMAX} + 1) begin
				ovf = 1;
				return VMIN;
			end
			return -q[CW-1:0];
		endfunction

		function automatic logic [63:0] floor_sqrt(logic [127:0] n);
			logic [63:0] r;
			logic [63:0] t;
			r = 0;
			for (int i = 63; i >= 0; i--) begin
				t = r | (64'd1 << i);
				if ({64'd0, t} * {64'd0, t} <= n) r = t;
			end
			return r;
		endfunction

		function automatic void note(deg_t deg, logic signed [CW-1:0] c,
				logic signed [CW-1:0] b, logic signed [CW-1:0] a);
			roots_t               e;
			logic signed [127:0]  cs, bs, as_, disc, negb, s, t1, t2;
			logic [63:0]          den;
			bit                   ovf;
			e = '{CASE_ALL, '0, '0, 1'b0};
			ovf = 0;
			cs = c;
			bs = b;
			as_ = a;
			den = (a < 0) ? -as_ : as_;
			den = den * 2;
			negb = -bs;
			case (deg)
				DEG_CONST: e.code = (c == 0) ? CASE_ALL : CASE_NONE;
				DEG_LINEAR: begin
					e.code = CASE_LINEAR;
					e.first = divide_sat(-cs, b < 0, (b < 0) ? -bs : bs, ovf);
				end
				DEG_QUAD: begin
					disc = bs * bs - 4 * as_ * cs;
					if (disc == 0) begin
						e.code = CASE_DOUBLE;
						e.first = divide_sat(negb, a < 0, den, ovf);
					end else if (disc > 0) begin
						e.code = CASE_REAL;
						s = floor_sqrt(disc);
						t1 = divide_sat(negb + s, a < 0, den, ovf);
						t2 = divide_sat(negb - s, a < 0, den, ovf);
						e.first = (t2 > t1) ? t2[CW-1:0] : t1[CW-1:0];
						e.second = (t2 > t1) ? t1[CW-1:0] : t2[CW-1:0];
					end else begin
						e.code = CASE_COMPLEX;
						s = floor_sqrt(-disc);
						e.first = divide_sat(negb, a < 0, den, ovf);
						e.second = divide_sat(s, a < 0, den, ovf);
					end
				end
				default: e.code = CASE_HIGH;
			endcase
			e.ovf = (deg == DEG_LINEAR || deg == DEG_QUAD) ? ovf : 1'b0;
			roots_q.push_back(e);
		endfunction

		function automatic void check(logic [2:0] code, logic signed [CW-1:0] first,
				logic signed [CW-1:0] second, logic ovf);
			roots_t e;
			if (roots_q.size() == 0) begin
				$error("unexpected result word: case_code %0d", code);
				fails++;
				return;
			end
			e = roots_q.pop_front();
			if (code !== e.code) begin
				$error("case_code expected %0d actual %0d", e.code, code);
				fails++;
			end
			if (first !== e.first) begin
				$error("first_value expected %0d actual %0d", e.first, first);
				fails++;
			end
			if (second !== e.second) begin
				$error("second_value expected %0d actual %0d", e.second, second);
				fails++;
			end
			if (ovf !== e.ovf) begin
				$error("overflow_flag expected %0d actual %0d", e.ovf, ovf);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   in_gap_max;
	int   out_gap_max;
	root_scoreboard sb;

	qrs_in_if  #(.COEF_WIDTH(CW)) req_if ();
	qrs_out_if #(.COEF_WIDTH(CW)) rsp_if ();

	quadratic_root_solver_top #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("quadratic_root_solver_top test failed");
			$finish;
		end
	end

	task automatic send_word(deg_t deg, logic signed [CW-1:0] c, logic signed [CW-1:0] b,
			logic signed [CW-1:0] a);
		int gap;
		gap = $urandom_range(in_gap_max, 0);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.poly_degree <= deg;
		req_if.coef_zero   <= c;
		req_if.coef_one    <= b;
		req_if.coef_two    <= a;
		do @(posedge clk); while (!req_if.ready);
		sb.note(deg, c, b, a);
	endtask

	function automatic logic signed [CW-1:0] rand_coef();
		case ($urandom_range(3, 0))
			0: return $urandom;
			1: return $signed($urandom_range(2 * 65536 * 64, 0)) - 65536 * 64;
			2: return $signed($urandom_range(2048, 0)) - 1024;
			default: return $urandom_range(1, 0) ? VMIN + $urandom_range(3, 0)
				: VMAX - $urandom_range(3, 0);
		endcase
	endfunction

	always begin
		int n;
		n = $urandom_range(out_gap_max, 0);
		if (n > 0) begin
			rsp_if.ready <= 1'b0;
			repeat (n) @(posedge clk);
		end
		rsp_if.ready <= 1'b1;
		do @(posedge clk); while (!(rsp_if.valid && arst_n));
		sb.check(rsp_if.case_code, rsp_if.first_value, rsp_if.second_value,
			rsp_if.overflow_flag);
	end

	initial begin
		logic signed [CW-1:0] p, t, sg;
		sb = new();
		in_gap_max = 0;
		out_gap_max = 0;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.poly_degree <= DEG_CONST;
		req_if.coef_zero <= '0;
		req_if.coef_one <= '0;
		req_if.coef_two <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(DEG_CONST, 0, 5, 7);
		send_word(DEG_CONST, VMIN, 0, 0);
		send_word(DEG_LINEAR, 0, 0, 3);
		send_word(DEG_LINEAR, 65536, 0, 0);
		send_word(DEG_LINEAR, -65536, 0, 0);
		send_word(DEG_LINEAR, 3 * 65536, 2 * 65536, 0);
		send_word(DEG_LINEAR, VMIN, 1, 0);
		send_word(DEG_LINEAR, VMAX, -1, 0);
		send_word(DEG_LINEAR, VMIN, -1, 0);
		send_word(DEG_LINEAR, VMIN, VMIN, VMIN);
		send_word(DEG_QUAD, 0, 0, 0);
		send_word(DEG_QUAD, 65536, 65536, 0);
		send_word(DEG_QUAD, 65536, 2 * 65536, 65536);
		send_word(DEG_QUAD, -4 * 65536, 0, 65536);
		send_word(DEG_QUAD, 65536, 0, 65536);
		send_word(DEG_QUAD, 65536, 0, -65536);
		send_word(DEG_QUAD, VMIN, VMIN, VMIN);
		send_word(DEG_QUAD, VMAX, VMAX, VMAX);
		send_word(DEG_QUAD, VMAX, VMIN, 1);
		send_word(DEG_QUAD, VMIN, VMAX, -1);
		send_word(DEG_QUAD, 0, 0, VMIN);
		send_word(DEG_HIGH, VMIN, VMAX, 1);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 200 == 0) begin
				in_gap_max = $urandom_range(1, 0) ? 5 : 0;
				out_gap_max = $urandom_range(1, 0) ? 5 : 0;
			end
			if ($urandom_range(9, 0) == 0) begin
				// perfect square discriminant: b = 2pt, c = p t^2
				p = $signed($urandom_range(2000, 1)) * ($urandom_range(1, 0) ? 1 : -1);
				t = $signed($urandom_range(400, 0)) - 200;
				sg = $urandom_range(1, 0) ? 1 : -1;
				send_word(DEG_QUAD, sg * p * t * t, sg * 2 * p * t, sg * p);
			end else begin
				send_word(deg_t'($urandom_range(3, 0)), rand_coef(), rand_coef(),
					rand_coef());
			end
		end
		req_if.valid <= 1'b0;

		while (sb.roots_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.fails == 0) begin
			$display("quadratic_root_solver_top test passed");
		end else begin
			$display("quadratic_root_solver_top test failed");
		end
		$finish;
	end
endmodule
